>>> rtl/distance_vector_route_table_unit_defines.svh
// ----------------------------------------------------------------------------
// distance vector route table unit: assertion macros
// Shared check macros for the route table block.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_UNIT_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define DVRT_ASSERT_SAME(lbl, clk_s, rst_ns, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_ns)) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define DVRT_ASSERT_NEXT(lbl, clk_s, rst_ns, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_ns)) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/dvrt_pkg.sv
// ----------------------------------------------------------------------------
// dvrt_pkg
// Types and constants shared by the route table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dvrt_pkg;

  // field widths
  localparam int ID_W       = 8;
  localparam int COST_W     = 32;
  localparam int AGE_W      = 16;
  localparam int CNT_W      = 9;
  localparam int CMD_W      = 2;
  localparam int CFG_DATA_W = 16;

  // cost and age limits
  localparam logic [COST_W-1:0] COST_UNREACH = '1;
  localparam logic [COST_W-1:0] COST_MAX     = 32'hFFFF_FFFE;
  localparam logic [AGE_W-1:0]  AGE_MAX      = '1;

  // request commands
  typedef enum logic [CMD_W-1:0] {
    CMD_SET_COST = 2'd0,
    CMD_ADVERT   = 2'd1,
    CMD_TICK     = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  // configuration register indexes
  typedef enum logic {
    REG_MY_ID   = 1'b0,
    REG_TIMEOUT = 1'b1
  } cfg_reg_t;

  // control sequencer states
  typedef enum logic [2:0] {
    S_CLEAR  = 3'd0,
    S_IDLE   = 3'd1,
    S_NB     = 3'd2,
    S_MERGE  = 3'd3,
    S_TICK   = 3'd4,
    S_FINISH = 3'd5
  } state_t;

  // one table row as stored in memory
  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [ID_W-1:0]   hop;
    logic              alive;
    logic [AGE_W-1:0]  age;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  // operands of one advertised-entry merge
  typedef struct packed {
    logic [ID_W-1:0]   node;
    logic [ID_W-1:0]   nb;
    logic [ID_W-1:0]   my_id;
    logic [COST_W-1:0] adv_cost;
    logic [COST_W-1:0] sum_cost;
    logic [ID_W-1:0]   hop_n;
  } merge_req_t;

endpackage

`default_nettype wire

>>> rtl/dvrt_ram.sv
// ----------------------------------------------------------------------------
// dvrt_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/dvrt_merge.sv
// ----------------------------------------------------------------------------
// dvrt_merge
// Merges one advertised entry into a destination row: poison, learn,
// shorter route and tie break toward the lower neighbor id.
// ----------------------------------------------------------------------------
`default_nettype none

module dvrt_merge (
  input  wire dvrt_pkg::row_t     row_i,
  input  wire dvrt_pkg::merge_req_t req,
  output dvrt_pkg::row_t          row_o,
  output logic                    changed
);

  logic                          adv_unr;
  logic                          poison;
  logic                          learn;
  logic                          shorter;
  logic                          tie;
  logic [dvrt_pkg::COST_W-1:0]   cost1;
  logic [dvrt_pkg::COST_W-1:0]   cost2;
  logic [dvrt_pkg::COST_W-1:0]   cost3;
  logic [dvrt_pkg::ID_W-1:0]     hop1;
  logic [dvrt_pkg::ID_W-1:0]     hop2;
  logic [dvrt_pkg::ID_W-1:0]     hop3;

  always_comb begin
    adv_unr = (req.adv_cost == dvrt_pkg::COST_UNREACH);

    // poison routes through the neighbor when it withdraws the destination
    poison = (req.node != req.my_id) && (row_i.hop == req.nb) && adv_unr &&
             (row_i.cost != dvrt_pkg::COST_UNREACH);
    cost1  = poison ? dvrt_pkg::COST_UNREACH : row_i.cost;
    hop1   = poison ? req.node : row_i.hop;

    // learn a route to an unreachable destination, via the neighbor's hop
    learn = (cost1 == dvrt_pkg::COST_UNREACH) && !adv_unr;
    cost2 = learn ? req.sum_cost : cost1;
    hop2  = learn ? req.hop_n : hop1;

    // strictly shorter route, else tie break on lower neighbor id
    shorter = (cost2 != dvrt_pkg::COST_UNREACH) && !adv_unr && (cost2 > req.sum_cost);
    tie     = !shorter && (cost2 == req.sum_cost) && !adv_unr;
    cost3   = shorter ? req.sum_cost : cost2;
    if (shorter || (tie && (hop2 > req.nb))) begin
      hop3 = req.nb;
    end else begin
      hop3 = hop2;
    end

    row_o      = row_i;
    row_o.cost = cost3;
    row_o.hop  = hop3;
    changed    = (cost3 != row_i.cost) || (hop3 != row_i.hop);
  end

endmodule

`default_nettype wire

>>> rtl/distance_vector_route_table_unit.sv
// ----------------------------------------------------------------------------
// distance_vector_route_table_unit
// Per-node distance vector routing table held in one row memory, updated by
// read-modify-write for cost sets, advertised entries, ticks and queries.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       request    in_valid/in_stall  cmd, node, neighbor, cost_value,
//                                          vector_start
//  out_      result     out_valid/out_stall changed, reachable, deliver_local,
//                                          route_next_hop, route_cost_out,
//                                          dropped_count
//  cfg_      write      cfg_valid/cfg_ready index, data
//
//  cost set and query read the row, then finish; an advertised entry reads the
//  neighbor row, then the destination row through the single memory read port,
//  then merges. a tick walks all NODE_COUNT rows, one a cycle, then finishes.
//  after reset a clearing pass writes every row with in_stall high;
//  configuration writes are taken throughout.
//  a stalled result holds the last step of its request until out_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

`include "distance_vector_route_table_unit_defines.svh"

module distance_vector_route_table_unit #(
  parameter int NODE_COUNT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [7:0]  in_node,
  input  wire logic [7:0]  in_neighbor,
  input  wire logic [31:0] in_cost_value,
  input  wire logic        in_vector_start,

  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_changed,
  output logic             out_reachable,
  output logic             out_deliver_local,
  output logic [7:0]       out_route_next_hop,
  output logic [31:0]      out_route_cost_out,
  output logic [8:0]       out_dropped_count,

  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int AW = $clog2(NODE_COUNT);
  localparam logic [AW-1:0] LAST_ROW = AW'(NODE_COUNT - 1);

  // sequencer
  dvrt_pkg::state_t state_r;
  dvrt_pkg::state_t state_nxt;

  // captured request
  dvrt_pkg::cmd_t                cmd_r;
  logic [dvrt_pkg::ID_W-1:0]     node_r;
  logic [dvrt_pkg::ID_W-1:0]     nb_r;
  logic [dvrt_pkg::COST_W-1:0]   cv_r;
  logic                          start_r;
  logic                          node_ok_r;
  logic                          nb_ok_r;

  // walk counter and tick tally
  logic [AW-1:0]                 row_r;
  logic [dvrt_pkg::CNT_W-1:0]    drop_cnt_r;

  // neighbor row results kept for the merge step
  dvrt_pkg::row_t                nrow_r;
  logic [dvrt_pkg::COST_W-1:0]   sum_r;
  logic                          nchg_r;

  // configuration
  logic [dvrt_pkg::ID_W-1:0]     my_id_r;
  logic [dvrt_pkg::AGE_W-1:0]    timeout_r;

  // result register
  logic                          out_valid_r;
  logic                          out_changed_r;
  logic                          out_reachable_r;
  logic                          out_local_r;
  logic [dvrt_pkg::ID_W-1:0]     out_hop_r;
  logic [dvrt_pkg::COST_W-1:0]   out_cost_r;
  logic [dvrt_pkg::CNT_W-1:0]    out_dropped_r;

  // memory port
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  dvrt_pkg::row_t                mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  dvrt_pkg::row_t                mem_rdata;

  // datapath
  logic                          in_accept;
  logic                          out_free;
  logic                          fin;
  logic [AW-1:0]                 node_addr;
  logic [AW-1:0]                 nb_addr;
  dvrt_pkg::row_t                nrow;
  logic                          nchg;
  logic [dvrt_pkg::COST_W:0]     sum_wide;
  logic [dvrt_pkg::COST_W-1:0]   sum_sat;
  dvrt_pkg::row_t                tick_row;
  logic [dvrt_pkg::AGE_W-1:0]    tick_age;
  logic                          tick_drop;
  dvrt_pkg::row_t                clear_row;
  dvrt_pkg::row_t                row_i;
  dvrt_pkg::row_t                merge_row;
  logic                          merge_chg;
  dvrt_pkg::merge_req_t          merge_req;
  logic                          res_changed;
  logic                          res_reachable;
  logic                          res_local;
  logic [dvrt_pkg::ID_W-1:0]     res_hop;
  logic [dvrt_pkg::COST_W-1:0]   res_cost;
  logic [dvrt_pkg::CNT_W-1:0]    res_dropped;

  assign in_stall  = (state_r != dvrt_pkg::S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign node_addr = AW'(node_r);
  assign nb_addr   = AW'(nb_r);

  // row memory
  dvrt_ram #(
    .WIDTH (dvrt_pkg::ROW_W),
    .DEPTH (NODE_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // neighbor row update and saturated path cost
  always_comb begin
    nrow       = mem_rdata;
    nrow.alive = 1'b1;
    nrow.age   = '0;
    nchg       = !mem_rdata.alive;
    if (start_r && (mem_rdata.cost == dvrt_pkg::COST_UNREACH)) begin
      nrow.cost = dvrt_pkg::COST_W'(1);
      nchg      = 1'b1;
    end
    sum_wide = {1'b0, cv_r} + {1'b0, nrow.cost};
    sum_sat  = (sum_wide > {1'b0, dvrt_pkg::COST_MAX}) ? dvrt_pkg::COST_MAX
                                                         : sum_wide[dvrt_pkg::COST_W-1:0];
  end

  // one row of the tick walk: age live neighbors, drop silent ones
  always_comb begin
    tick_row  = mem_rdata;
    tick_age  = (mem_rdata.age != dvrt_pkg::AGE_MAX) ?
                mem_rdata.age + dvrt_pkg::AGE_W'(1) : mem_rdata.age;
    tick_drop = mem_rdata.alive && (tick_age >= timeout_r);
    if (mem_rdata.alive) begin
      tick_row.age = tick_age;
    end
    if (tick_drop) begin
      tick_row.alive = 1'b0;
      tick_row.cost  = dvrt_pkg::COST_UNREACH;
      tick_row.hop   = dvrt_pkg::ID_W'(row_r);
    end
  end

  // reset contents of the row under the walk counter
  always_comb begin
    clear_row.cost  = dvrt_pkg::COST_UNREACH;
    clear_row.hop   = dvrt_pkg::ID_W'(row_r);
    clear_row.alive = 1'b0;
    clear_row.age   = '0;
  end

  // destination row, forwarded when it is the neighbor row just written
  assign row_i = (node_r == nb_r) ? nrow_r : mem_rdata;

  always_comb begin
    merge_req.node     = node_r;
    merge_req.nb       = nb_r;
    merge_req.my_id    = my_id_r;
    merge_req.adv_cost = cv_r;
    merge_req.sum_cost = sum_r;
    merge_req.hop_n    = nrow_r.hop;
  end

  dvrt_merge u_merge (
    .row_i   (row_i),
    .req     (merge_req),
    .row_o   (merge_row),
    .changed (merge_chg)
  );

  // next state, memory control and result
  always_comb begin
    state_nxt     = state_r;
    mem_we        = 1'b0;
    mem_waddr     = node_addr;
    mem_wdata     = mem_rdata;
    mem_raddr     = node_addr;
    fin           = 1'b0;
    res_changed   = 1'b0;
    res_reachable = 1'b0;
    res_local     = 1'b0;
    res_hop       = '0;
    res_cost      = '0;
    res_dropped   = '0;
    case (state_r)
      dvrt_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = clear_row;
        if (row_r == LAST_ROW) begin
          state_nxt = dvrt_pkg::S_IDLE;
        end
      end
      dvrt_pkg::S_IDLE: begin
        case (dvrt_pkg::cmd_t'(in_cmd))
          dvrt_pkg::CMD_ADVERT: mem_raddr = AW'(in_neighbor);
          dvrt_pkg::CMD_TICK:   mem_raddr = '0;
          default:              mem_raddr = AW'(in_node);
        endcase
        if (in_valid) begin
          case (dvrt_pkg::cmd_t'(in_cmd))
            dvrt_pkg::CMD_ADVERT: state_nxt = dvrt_pkg::S_NB;
            dvrt_pkg::CMD_TICK:   state_nxt = dvrt_pkg::S_TICK;
            default:              state_nxt = dvrt_pkg::S_FINISH;
          endcase
        end
      end
      dvrt_pkg::S_NB: begin
        mem_we    = nb_ok_r;
        mem_waddr = nb_addr;
        mem_wdata = nrow;
        state_nxt = dvrt_pkg::S_MERGE;
      end
      dvrt_pkg::S_MERGE: begin
        if (out_free) begin
          mem_we      = nb_ok_r && node_ok_r;
          mem_wdata   = merge_row;
          fin         = 1'b1;
          res_changed = nb_ok_r && (nchg_r || (node_ok_r && merge_chg));
          state_nxt   = dvrt_pkg::S_IDLE;
        end
      end
      dvrt_pkg::S_TICK: begin
        mem_raddr = row_r + AW'(1);
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = tick_row;
        if (row_r == LAST_ROW) begin
          state_nxt = dvrt_pkg::S_FINISH;
        end
      end
      dvrt_pkg::S_FINISH: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = dvrt_pkg::S_IDLE;
          case (cmd_r)
            dvrt_pkg::CMD_SET_COST: begin
              mem_we         = node_ok_r;
              mem_wdata.cost = cv_r;
              res_changed    = node_ok_r && (mem_rdata.cost != cv_r);
            end
            dvrt_pkg::CMD_QUERY: begin
              res_cost      = node_ok_r ? mem_rdata.cost : dvrt_pkg::COST_UNREACH;
              res_hop       = node_ok_r ? mem_rdata.hop : node_r;
              res_reachable = node_ok_r && (mem_rdata.cost != dvrt_pkg::COST_UNREACH);
              res_local     = (node_r == my_id_r);
            end
            dvrt_pkg::CMD_TICK: begin
              res_dropped = drop_cnt_r;
              res_changed = (drop_cnt_r != '0);
            end
            default: begin
              res_changed = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = dvrt_pkg::S_IDLE;
      end
    endcase
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dvrt_pkg::S_CLEAR;
      row_r       <= '0;
      out_valid_r <= 1'b0;
      my_id_r     <= '0;
      timeout_r   <= dvrt_pkg::AGE_W'(2);
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        row_r <= '0;
      end else if ((state_r == dvrt_pkg::S_CLEAR) || (state_r == dvrt_pkg::S_TICK)) begin
        row_r <= row_r + AW'(1);
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      // configuration write
      if (cfg_valid && cfg_ready) begin
        case (dvrt_pkg::cfg_reg_t'(cfg_index))
          dvrt_pkg::REG_MY_ID:   my_id_r   <= cfg_data[dvrt_pkg::ID_W-1:0];
          dvrt_pkg::REG_TIMEOUT: timeout_r <= cfg_data;
          default:               my_id_r   <= my_id_r;
        endcase
      end
    end
  end

  // request capture and working payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r      <= dvrt_pkg::cmd_t'(in_cmd);
      node_r     <= in_node;
      nb_r       <= in_neighbor;
      cv_r       <= in_cost_value;
      start_r    <= in_vector_start;
      node_ok_r  <= (32'(in_node) < NODE_COUNT);
      nb_ok_r    <= (32'(in_neighbor) < NODE_COUNT);
      drop_cnt_r <= '0;
    end else if (state_r == dvrt_pkg::S_TICK) begin
      drop_cnt_r <= drop_cnt_r + dvrt_pkg::CNT_W'(tick_drop);
    end
    if (state_r == dvrt_pkg::S_NB) begin
      nrow_r <= nrow;
      sum_r  <= sum_sat;
      nchg_r <= nchg;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (fin) begin
      out_changed_r   <= res_changed;
      out_reachable_r <= res_reachable;
      out_local_r     <= res_local;
      out_hop_r       <= res_hop;
      out_cost_r      <= res_cost;
      out_dropped_r   <= res_dropped;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_changed        = out_changed_r;
  assign out_reachable      = out_reachable_r;
  assign out_deliver_local  = out_local_r;
  assign out_route_next_hop = out_hop_r;
  assign out_route_cost_out = out_cost_r;
  assign out_dropped_count  = out_dropped_r;

  // checks
  `DVRT_ASSERT_SAME(a_idle_no_write, clk, rst_n, state_r == dvrt_pkg::S_IDLE, !mem_we, "row memory written while idle")
  `DVRT_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_accept, state_r != dvrt_pkg::S_IDLE, "accepted request did not start")
  `DVRT_ASSERT_SAME(a_result_source, clk, rst_n, $rose(out_valid_r), $past(state_r) == dvrt_pkg::S_FINISH || $past(state_r) == dvrt_pkg::S_MERGE, "result raised outside a final step")
  `DVRT_ASSERT_SAME(a_tick_walk, clk, rst_n, state_r == dvrt_pkg::S_TICK, mem_we && (mem_waddr == row_r), "tick walk skipped a row write")

endmodule

`default_nettype wire
